FILE: rtl/core/path_lookahead_target_unit_macros.svh
// Assertion macros for the path lookahead target unit
`ifndef PATH_LOOKAHEAD_TARGET_UNIT_MACROS_SVH
`define PATH_LOOKAHEAD_TARGET_UNIT_MACROS_SVH
// implication checked at every rising clock edge outside reset
`define PLT_ASSERT_IMP(label, clk, rst, lhs, rhs) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |-> (rhs)) \
      else $error("assertion failed");
// implication whose consequent is checked in the cycle after the antecedent
`define PLT_ASSERT_NEXT(label, clk, rst, lhs, rhs) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |=> (rhs)) \
      else $error("assertion failed");
`endif

FILE: rtl/core/plt_pkg.sv
// Package: shared types and constants of the path lookahead target unit
package plt_pkg;
   localparam logic [1:0] OP_CLEAR  = 2'd0;
   localparam logic [1:0] OP_APPEND = 2'd1;
   localparam logic [1:0] OP_QUERY  = 2'd2;
   localparam logic [1:0] OP_UNUSED = 2'd3;

   localparam logic [2:0] ST_CLEARED  = 3'd0;
   localparam logic [2:0] ST_APPENDED = 3'd1;
   localparam logic [2:0] ST_DROPPED  = 3'd2;
   localparam logic [2:0] ST_FOUND    = 3'd3;
   localparam logic [2:0] ST_LAST     = 3'd4;
   localparam logic [2:0] ST_FALLBACK = 3'd5;

   localparam logic [31:0] NEAR_STOP = 32'd6554;
   localparam logic [31:0] FAR_LIMIT = 32'd65536;

   typedef enum logic [3:0] {
      S_IDLE, S_RD, S_RDW, S_DIFF, S_SQR, S_SUM, S_ROOT, S_NEAR,
      S_SEG, S_OUT, S_HOLD
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic take;       // capture the request
      logic clear;
      logic append;
      logic rd_start;   // begin the nearest scan at index zero
      logic rd_issue;   // issue memory read for current index
      logic rd_latch;   // capture read data
      logic diff;
      logic sqr;
      logic sum;
      logic root_start;
      logic root_step;
      logic near_eval;
      logic seg_eval;
      logic fin_simple;
      logic fin_query;
      logic rsp_load;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic [1:0] op;
      logic short_path;
      logic root_done;
      logic scan_done;  // near search finished
      logic walk_done;  // walk finished
      logic walking;
   } sts_type;
endpackage

FILE: rtl/core/plt_if.sv
// Interfaces: request and response channels
interface plt_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  op;
   logic signed [31:0] point_x;
   logic signed [31:0] point_y;
   logic signed [31:0] point_z;
   logic signed [31:0] here_x;
   logic signed [31:0] here_y;
   logic signed [31:0] here_z;
   logic [30:0] reach;
   modport source (output valid, op, point_x, point_y, point_z, here_x, here_y, here_z,
                   reach, input ready);
   modport sink (input valid, op, point_x, point_y, point_z, here_x, here_y, here_z,
                 reach, output ready);
endinterface

interface plt_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  status;
   logic signed [31:0] aim_x;
   logic signed [31:0] aim_y;
   logic signed [31:0] aim_z;
   logic [7:0]  aim_index;
   modport source (output valid, status, aim_x, aim_y, aim_z, aim_index, input ready);
   modport sink (input valid, status, aim_x, aim_y, aim_z, aim_index, output ready);
endinterface

FILE: rtl/core/plt_ctrl.sv
// Controller: sequences loads and the two phases of a query
module plt_ctrl
   import plt_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   input  logic    rsp_busy,
   input  sts_type sts,
   output logic    req_ready,
   output cmd_type cmd
);
   state_type state_ff, state_in;

   // hold state
   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_IDLE;
      else       state_ff <= state_in;
   end

   // next state and commands
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_ready = !rsp_busy;
            if (req_valid && !rsp_busy) begin
               cmd.take = 1'b1;
               state_in = S_HOLD;
            end
         end
         S_HOLD: begin
            unique case (sts.op)
               OP_CLEAR: begin
                  cmd.clear = 1'b1;
                  cmd.fin_simple = 1'b1;
                  state_in = S_OUT;
               end
               OP_APPEND: begin
                  cmd.append = 1'b1;
                  cmd.fin_simple = 1'b1;
                  state_in = S_OUT;
               end
               OP_QUERY: begin
                  if (sts.short_path) begin
                     cmd.fin_query = 1'b1;
                     state_in = S_OUT;
                  end else begin
                     cmd.rd_start = 1'b1;
                     state_in = S_RD;
                  end
               end
               default: state_in = S_IDLE;
            endcase
         end
         S_RD: begin
            cmd.rd_issue = 1'b1;
            state_in = S_RDW;
         end
         S_RDW: begin
            cmd.rd_latch = 1'b1;
            state_in = S_DIFF;
         end
         S_DIFF: begin
            cmd.diff = 1'b1;
            state_in = S_SQR;
         end
         S_SQR: begin
            cmd.sqr = 1'b1;
            state_in = S_SUM;
         end
         S_SUM: begin
            cmd.sum = 1'b1;
            cmd.root_start = 1'b1;
            state_in = S_ROOT;
         end
         S_ROOT: begin
            cmd.root_step = 1'b1;
            if (sts.root_done) state_in = S_NEAR;
         end
         S_NEAR: begin
            if (sts.walking) cmd.seg_eval = 1'b1;
            else             cmd.near_eval = 1'b1;
            state_in = S_SEG;
         end
         S_SEG: begin
            if (sts.scan_done || sts.walk_done) begin
               if (sts.walk_done) begin
                  cmd.fin_query = 1'b1;
                  state_in = S_OUT;
               end else state_in = S_RD;
            end else state_in = S_RD;
         end
         S_OUT: begin
            cmd.rsp_load = 1'b1;
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end
endmodule

FILE: rtl/core/plt_path.sv
// Datapath: waypoint memory, distance unit with iterative root, result build
module plt_path
   import plt_pkg::*;
#(
   parameter int MAX_POINTS = 256,
   parameter int AW = 8,
   parameter int CW = 9
) (
   input  logic        clock,
   input  logic        reset,
   input  cmd_type     cmd,
   output sts_type     sts,
   input  logic [1:0]  req_op,
   input  logic [31:0] req_point_x,
   input  logic [31:0] req_point_y,
   input  logic [31:0] req_point_z,
   input  logic [31:0] req_here_x,
   input  logic [31:0] req_here_y,
   input  logic [31:0] req_here_z,
   input  logic [30:0] req_reach,
   output logic [2:0]  res_status,
   output logic [31:0] res_x,
   output logic [31:0] res_y,
   output logic [31:0] res_z,
   output logic [7:0]  res_index
);
   logic [95:0] mem [MAX_POINTS];
   logic [95:0] rd_ff;
   logic [CW-1:0] count_ff;
   logic [1:0]  op_ff;
   logic [31:0] pt_x_ff, pt_y_ff, pt_z_ff, hx_ff, hy_ff, hz_ff;
   logic [30:0] reach_ff;
   logic [CW-1:0] idx_ff;        // index being read
   logic        walking_ff;
   logic [31:0] prev_x_ff, prev_y_ff;   // previous waypoint (walk) or here (scan)
   logic [31:0] cur_x_ff, cur_y_ff, cur_z_ff;
   logic [31:0] nx_ff, ny_ff, nz_ff;     // nearest waypoint found so far
   logic [32:0] dx_ff, dy_ff;
   logic [65:0] sx_ff, sy_ff;
   logic [66:0] sq_ff;
   logic [66:0] sq_sum;
   logic        sat_ff;
   logic [33:0] root_r_ff;
   logic [5:0]  root_n_ff;
   logic [63:0] rad_ff;
   logic [33:0] rem_ff;
   logic [33:0] rem_sh;
   logic [33:0] rtry;
   logic [31:0] pt_span;
   logic [31:0] best_ff;
   logic [CW-1:0] near_ff;
   logic        scan_done_ff, walk_done_ff;
   logic [63:0] accum_ff;
   logic [32:0] look_ff;
   logic [2:0]  st_ff;
   logic [31:0] ox_ff, oy_ff, oz_ff;
   logic [7:0]  oi_ff;
   logic [CW-1:0] last_idx;
   logic [CW-1:0] rd_idx;
   logic [AW-1:0] rd_addr, wr_addr;
   logic [32:0] ax, ay;
   logic [63:0] accum_n;
   logic        take_cur, scan_end;
   logic [CW-1:0] nb;
   logic [31:0] bd, nx, ny, nz;

   assign last_idx = count_ff - CW'(1);
   assign rd_idx   = cmd.rd_start ? '0 : idx_ff;
   assign rd_addr  = idx_ff[AW-1:0];
   assign wr_addr  = count_ff[AW-1:0];

   // store waypoints and read one per request
   always_ff @(posedge clock) begin
      if (cmd.append && count_ff < CW'(MAX_POINTS))
         mem[wr_addr] <= {pt_z_ff, pt_y_ff, pt_x_ff};
      if (cmd.rd_issue) rd_ff <= mem[rd_addr];
   end

   // hold the request
   always_ff @(posedge clock) begin
      if (cmd.take) begin
         op_ff <= req_op;
         pt_x_ff <= req_point_x; pt_y_ff <= req_point_y; pt_z_ff <= req_point_z;
         hx_ff <= req_here_x; hy_ff <= req_here_y; hz_ff <= req_here_z;
         reach_ff <= req_reach;
      end
   end

   // point count
   always_ff @(posedge clock) begin
      if (reset) count_ff <= '0;
      else if (cmd.clear) count_ff <= '0;
      else if (cmd.append && count_ff < CW'(MAX_POINTS)) count_ff <= count_ff + CW'(1);
   end

   // distance pipeline: differences, squares, sum
   assign ax = dx_ff[32] ? -dx_ff : dx_ff;
   assign ay = dy_ff[32] ? -dy_ff : dy_ff;
   assign sq_sum = {1'b0, sx_ff} + {1'b0, sy_ff};
   always_ff @(posedge clock) begin
      if (cmd.rd_latch) begin
         cur_x_ff <= rd_ff[31:0]; cur_y_ff <= rd_ff[63:32]; cur_z_ff <= rd_ff[95:64];
      end
      if (cmd.diff) begin
         dx_ff <= {cur_x_ff[31], cur_x_ff} - {prev_x_ff[31], prev_x_ff};
         dy_ff <= {cur_y_ff[31], cur_y_ff} - {prev_y_ff[31], prev_y_ff};
      end
      if (cmd.sqr) begin
         sx_ff <= ax * ax;
         sy_ff <= ay * ay;
         sat_ff <= ax[32] || ay[32];
      end
      if (cmd.sum) sq_ff <= sq_sum;
   end

   // restoring root over a 64-bit radicand, two radicand bits and one result bit per step
   assign rem_sh = {rem_ff[31:0], rad_ff[63:62]};
   assign rtry   = {root_r_ff[31:0], 2'b01};
   always_ff @(posedge clock) begin
      if (cmd.root_start) begin
         rad_ff <= sq_sum[63:0];
         rem_ff <= '0;
         root_r_ff <= '0;
         root_n_ff <= 6'd0;
      end else if (cmd.root_step) begin
         rad_ff <= {rad_ff[61:0], 2'b00};
         root_n_ff <= root_n_ff + 6'd1;
         if (rem_sh >= rtry) begin
            rem_ff <= rem_sh - rtry;
            root_r_ff <= {root_r_ff[32:0], 1'b1};
         end else begin
            rem_ff <= rem_sh;
            root_r_ff <= {root_r_ff[32:0], 1'b0};
         end
      end
   end
   assign pt_span = (sat_ff || sq_ff[66:64] != 3'd0) ? 32'hFFFF_FFFF : root_r_ff[31:0];

   // pick the current waypoint as nearest: first one, near stop or strictly closer
   assign accum_n  = accum_ff + {32'd0, pt_span};
   assign take_cur = (pt_span < NEAR_STOP) || (pt_span < best_ff) || (idx_ff == '0);
   assign scan_end = (pt_span < NEAR_STOP) || (idx_ff == last_idx);
   assign nb = take_cur ? idx_ff : near_ff;
   assign bd = take_cur ? pt_span : best_ff;
   assign nx = take_cur ? cur_x_ff : nx_ff;
   assign ny = take_cur ? cur_y_ff : ny_ff;
   assign nz = take_cur ? cur_z_ff : nz_ff;

   // scan for nearest, then walk segments
   always_ff @(posedge clock) begin
      if (reset) begin
         walking_ff <= 1'b0;
         scan_done_ff <= 1'b0;
         walk_done_ff <= 1'b0;
      end else begin
         scan_done_ff <= cmd.near_eval && scan_end;
         if (cmd.append)
            st_ff <= (count_ff < CW'(MAX_POINTS)) ? ST_APPENDED : ST_DROPPED;
         if (cmd.rd_start) begin
            walking_ff <= 1'b0;
            walk_done_ff <= 1'b0;
            idx_ff <= rd_idx;
            prev_x_ff <= hx_ff; prev_y_ff <= hy_ff;
            best_ff <= 32'hFFFF_FFFF;
            near_ff <= '0;
            accum_ff <= '0;
         end
         if (cmd.near_eval) begin
            best_ff <= bd; near_ff <= nb;
            nx_ff <= nx; ny_ff <= ny; nz_ff <= nz;
            if (scan_end) begin
               // nearest fixed: set the lookahead and start the walk from it
               look_ff <= (bd > FAR_LIMIT) ? ({2'b0, reach_ff} + {3'b0, reach_ff[30:1]})
                                           : {2'b0, reach_ff};
               walking_ff <= 1'b1;
               prev_x_ff <= nx; prev_y_ff <= ny;
               if (nb == last_idx) begin
                  walk_done_ff <= 1'b1;
                  st_ff <= ST_LAST;
                  ox_ff <= nx; oy_ff <= ny; oz_ff <= nz;
                  oi_ff <= 8'(nb);
               end else idx_ff <= nb + CW'(1);
            end else idx_ff <= idx_ff + CW'(1);
         end
         if (cmd.seg_eval) begin
            accum_ff <= accum_n;
            prev_x_ff <= cur_x_ff; prev_y_ff <= cur_y_ff;
            if (accum_n >= {31'd0, look_ff}) begin
               walk_done_ff <= 1'b1;
               st_ff <= ST_FOUND;
               ox_ff <= cur_x_ff; oy_ff <= cur_y_ff; oz_ff <= cur_z_ff;
               oi_ff <= 8'(idx_ff);
            end else if (idx_ff == last_idx) begin
               walk_done_ff <= 1'b1;
               st_ff <= ST_LAST;
               ox_ff <= cur_x_ff; oy_ff <= cur_y_ff; oz_ff <= cur_z_ff;
               oi_ff <= 8'(idx_ff);
            end else idx_ff <= idx_ff + CW'(1);
         end
      end
   end

   // status to the controller
   always_comb begin
      sts.op         = op_ff;
      sts.short_path = count_ff < CW'(2);
      sts.root_done  = (root_n_ff == 6'd31) && cmd.root_step;
      sts.scan_done  = scan_done_ff;
      sts.walk_done  = walk_done_ff;
      sts.walking    = walking_ff;
   end

   // result build
   always_comb begin
      res_status = ST_CLEARED;
      res_x = '0; res_y = '0; res_z = '0; res_index = '0;
      case (op_ff)
         OP_CLEAR:  res_status = ST_CLEARED;
         OP_APPEND: res_status = st_ff;
         default: begin
            if (count_ff < CW'(2)) begin
               res_status = ST_FALLBACK;
               res_x = hx_ff; res_y = hy_ff; res_z = hz_ff;
            end else begin
               res_status = st_ff;
               res_x = ox_ff; res_y = oy_ff; res_z = oz_ff; res_index = oi_ff;
            end
         end
      endcase
   end
endmodule

FILE: rtl/core/path_lookahead_target_unit.sv
// A load passes the hold and output states to the response register; the next transaction
// is taken once that response is accepted. A query reads, differences, squares, sums and
// roots (one result bit per cycle) each waypoint, visiting at most twice the point count.
// One transaction is in flight at a time; the response register parts the two sides.
// Reset clears the point count and control; the waypoint memory is undefined
// until written.
module path_lookahead_target_unit
   import plt_pkg::*;
#(
   parameter int MAX_POINTS = 256
) (
   input logic clock,
   input logic reset,
   plt_req_if.sink   req,
   plt_rsp_if.source rsp
);
`include "path_lookahead_target_unit_macros.svh"
   localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
   localparam int CW = $clog2(MAX_POINTS + 1);
   cmd_type cmd;
   sts_type sts;
   logic        rv_ff;
   logic [2:0]  rs_ff, r_status;
   logic [31:0] rx_ff, ry_ff, rz_ff, r_x, r_y, r_z;
   logic [7:0]  ri_ff, r_index;
   logic        req_ready;
   logic [1:0]  op_eff;

   assign op_eff = req.op;
   plt_ctrl u_ctrl (.clock, .reset, .req_valid(req.valid && req.op != OP_UNUSED),
                    .rsp_busy(rv_ff), .sts, .req_ready, .cmd);
   assign req.ready = req_ready;

   plt_path #(.MAX_POINTS(MAX_POINTS), .AW(AW), .CW(CW)) u_path (
      .clock, .reset, .cmd, .sts,
      .req_op(op_eff), .req_point_x(req.point_x), .req_point_y(req.point_y),
      .req_point_z(req.point_z), .req_here_x(req.here_x), .req_here_y(req.here_y),
      .req_here_z(req.here_z), .req_reach(req.reach),
      .res_status(r_status), .res_x(r_x), .res_y(r_y), .res_z(r_z), .res_index(r_index));

   // response register
   always_ff @(posedge clock) begin
      if (reset) rv_ff <= 1'b0;
      else if (cmd.rsp_load) rv_ff <= 1'b1;
      else if (rsp.ready) rv_ff <= 1'b0;
      if (cmd.rsp_load) begin
         rs_ff <= r_status; rx_ff <= r_x; ry_ff <= r_y; rz_ff <= r_z; ri_ff <= r_index;
      end
   end
   assign rsp.valid = rv_ff;
   assign rsp.status = rs_ff;
   assign rsp.aim_x = rx_ff;
   assign rsp.aim_y = ry_ff;
   assign rsp.aim_z = rz_ff;
   assign rsp.aim_index = ri_ff;

   `PLT_ASSERT_IMP(a_no_take_busy, clock, reset, rv_ff, !cmd.take)
   `PLT_ASSERT_NEXT(a_load_valid, clock, reset, cmd.rsp_load, rv_ff)
endmodule
